// File: rtl/core/div64_pkg.sv
// ----------------------------------------------------------------------------
// div64_pkg
// Shared types and constants for the radix-2 restoring divider.
// ----------------------------------------------------------------------------
package div64_pkg;

  // Payload width of the operand and result fields on the channels.
  localparam int unsigned PORT_BITS     = 64;
  // Default arithmetic width of the divider core.
  localparam int unsigned WORD_BITS_DEF = 64;

  // Operations of the shared subtract unit.
  typedef enum logic [1:0] {
    ALU_PASS,   // result = x
    ALU_NEG,    // result = 0 - x
    ALU_STEP    // one shift-subtract quotient step
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    bit_in;   // dividend bit shifted into the partial remainder
  } alu_ctrl_t;

endpackage

// File: rtl/core/div64_in_if.sv
// ----------------------------------------------------------------------------
// div64_in_if
// Operand channel: mode bit, dividend and divisor with valid/ready.
// ----------------------------------------------------------------------------
interface div64_in_if import div64_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [PORT_BITS-1:0] dividend;
  logic [PORT_BITS-1:0] divisor;

  modport source (output valid, output func, output dividend, output divisor, input ready);
  modport sink   (input valid, input func, input dividend, input divisor, output ready);

endinterface

// File: rtl/core/div64_out_if.sv
// ----------------------------------------------------------------------------
// div64_out_if
// Result channel: quotient, remainder and divide-by-zero flag with valid/ready.
// ----------------------------------------------------------------------------
interface div64_out_if import div64_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [PORT_BITS-1:0] quotient;
  logic [PORT_BITS-1:0] remainder;
  logic                 divide_by_zero;

  modport source (output valid, output quotient, output remainder, output divide_by_zero,
                  input ready);
  modport sink   (input valid, input quotient, input remainder, input divide_by_zero,
                  output ready);

endinterface

// File: rtl/core/div64_alu.sv
// ----------------------------------------------------------------------------
// div64_alu
// Shared subtractor: pass, negate, or one restoring shift-subtract step.
// ----------------------------------------------------------------------------
module div64_alu import div64_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  alu_ctrl_t             ctrl,
  input  logic [WORD_BITS-1:0]  x,
  input  logic [WORD_BITS-1:0]  y,
  output logic [WORD_BITS-1:0]  res,
  output logic                  taken
);

  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS:0]   minu;
  logic [WORD_BITS:0]   subt;
  logic [WORD_BITS+1:0] diff;

  assign shifted = {x, ctrl.bit_in};

  always_comb begin
    unique case (ctrl.op)
      ALU_STEP: begin
        minu = shifted;
        subt = {1'b0, y};
      end
      ALU_NEG: begin
        minu = '0;
        subt = {1'b0, x};
      end
      default: begin
        minu = {1'b0, x};
        subt = '0;
      end
    endcase
  end

  // One extra bit so the borrow shows even for a W+1 bit minuend.
  assign diff = {1'b0, minu} - {1'b0, subt};

  always_comb begin
    unique case (ctrl.op)
      ALU_STEP: begin
        taken = ~diff[WORD_BITS+1];
        res   = taken ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
      end
      ALU_NEG: begin
        taken = 1'b1;
        res   = diff[WORD_BITS-1:0];
      end
      default: begin
        taken = 1'b1;
        res   = x;
      end
    endcase
  end

endmodule

// File: rtl/core/divider_64bit_signed_unsigned_top.sv
// ----------------------------------------------------------------------------
// divider_64bit_signed_unsigned_top
// Radix-2 restoring divider, unsigned or two's complement signed.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one transaction per division: func (0 unsigned, 1 signed),
//   dividend and divisor. Only the low WORD_BITS bits of the operands count.
//   out_ch returns quotient, remainder and divide_by_zero; result bits above
//   WORD_BITS are zero.
// Operation:
//   One subtractor is shared by all steps. After an accepted transaction the
//   sequencer forms |dividend|, then |divisor|, runs the bit-serial
//   shift-subtract loop that builds the quotient, fixes the quotient sign,
//   then fixes the remainder sign and loads the output register.
//   in_ch.ready rises when the result is loaded, so the next transaction is
//   taken only after the previous division has finished.
//   A zero divisor skips the arithmetic and goes straight to the last step:
//   flag set, quotient all ones, remainder the dividend.
// Reset and stall:
//   rst_n (synchronous, active low) drops any division in progress and the
//   pending result. The output register holds a result until out_ch.ready;
//   a finished division waits in the last step while the register is full,
//   and a new transaction is taken while an older result still waits.
// ----------------------------------------------------------------------------
module divider_64bit_signed_unsigned_top import div64_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  div64_in_if.sink     in_ch,
  div64_out_if.source  out_ch
);

  localparam int unsigned CNT_W = $clog2(WORD_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ABS_A,
    S_ABS_B,
    S_DIV,
    S_NEG_Q,
    S_NEG_R
  } state_t;

  state_t               state_r;
  logic [WORD_BITS-1:0] quo_r;     // |dividend| shifting out, quotient shifting in
  logic [WORD_BITS-1:0] rem_r;     // partial remainder
  logic [WORD_BITS-1:0] dvs_r;     // |divisor|
  logic [CNT_W-1:0]     cnt_r;
  logic                 neg_r_r;   // dividend negative: remainder sign
  logic                 neg_d_r;   // divisor negative
  logic                 neg_q_r;   // signs differ: negate quotient
  logic                 dbz_r;

  logic [WORD_BITS-1:0] out_q_r;
  logic [WORD_BITS-1:0] out_rem_r;
  logic                 out_dbz_r;
  logic                 out_valid_r;

  alu_ctrl_t            alu_ctrl;
  logic [WORD_BITS-1:0] alu_x;
  logic [WORD_BITS-1:0] alu_res;
  logic                 alu_taken;

  logic [WORD_BITS-1:0] in_a;
  logic [WORD_BITS-1:0] in_b;
  logic                 in_fire;
  logic                 out_free;
  logic                 sign_a;
  logic                 sign_b;

  assign in_a     = in_ch.dividend[WORD_BITS-1:0];
  assign in_b     = in_ch.divisor[WORD_BITS-1:0];
  assign sign_a   = in_ch.func & in_a[WORD_BITS-1];
  assign sign_b   = in_ch.func & in_b[WORD_BITS-1];
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_free = ~out_valid_r | out_ch.ready;

  // Operand and operation select for the shared unit
  always_comb begin
    alu_ctrl.bit_in = quo_r[WORD_BITS-1];
    unique case (state_r)
      S_ABS_A: begin
        alu_ctrl.op = neg_r_r ? ALU_NEG : ALU_PASS;
        alu_x       = quo_r;
      end
      S_ABS_B: begin
        alu_ctrl.op = neg_d_r ? ALU_NEG : ALU_PASS;
        alu_x       = dvs_r;
      end
      S_DIV: begin
        alu_ctrl.op = ALU_STEP;
        alu_x       = rem_r;
      end
      S_NEG_Q: begin
        alu_ctrl.op = neg_q_r ? ALU_NEG : ALU_PASS;
        alu_x       = quo_r;
      end
      S_NEG_R: begin
        alu_ctrl.op = neg_r_r ? ALU_NEG : ALU_PASS;
        alu_x       = rem_r;
      end
      default: begin
        alu_ctrl.op = ALU_PASS;
        alu_x       = rem_r;
      end
    endcase
  end

  div64_alu #(
    .WORD_BITS (WORD_BITS)
  ) u_alu (
    .ctrl  (alu_ctrl),
    .x     (alu_x),
    .y     (dvs_r),
    .res   (alu_res),
    .taken (alu_taken)
  );

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_NEG_R && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cnt_r <= CNT_W'(WORD_BITS - 1);
            if (in_b == '0) begin
              // zero divisor: load the fixed result and go straight out
              quo_r   <= '1;
              rem_r   <= in_a;
              dvs_r   <= in_b;
              neg_r_r <= 1'b0;
              neg_d_r <= 1'b0;
              neg_q_r <= 1'b0;
              dbz_r   <= 1'b1;
              state_r <= S_NEG_R;
            end else begin
              quo_r   <= in_a;
              rem_r   <= '0;
              dvs_r   <= in_b;
              neg_r_r <= sign_a;
              neg_d_r <= sign_b;
              neg_q_r <= sign_a ^ sign_b;
              dbz_r   <= 1'b0;
              state_r <= S_ABS_A;
            end
          end
        end
        S_ABS_A: begin
          quo_r   <= alu_res;
          state_r <= S_ABS_B;
        end
        S_ABS_B: begin
          dvs_r   <= alu_res;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= alu_res;
          quo_r <= {quo_r[WORD_BITS-2:0], alu_taken};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_NEG_Q;
          end
        end
        S_NEG_Q: begin
          quo_r   <= alu_res;
          state_r <= S_NEG_R;
        end
        S_NEG_R: begin
          if (out_free) begin
            out_q_r   <= quo_r;
            out_rem_r <= alu_res;
            out_dbz_r <= dbz_r;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.quotient       = PORT_BITS'(out_q_r);
  assign out_ch.remainder      = PORT_BITS'(out_rem_r);
  assign out_ch.divide_by_zero = out_dbz_r;

  // Assertions
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("accepted transaction did not start a division");

  a_div_runs_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r != '0) |=> state_r == S_DIV)
    else $error("quotient loop ended early");

  a_dbz_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dbz_r) |-> out_q_r == {WORD_BITS{1'b1}})
    else $error("divide by zero without all-ones quotient");

  a_result_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_NEG_R)
    else $error("result loaded outside the final step");

endmodule
